// ===== rtl/hbms_pkg.sv =====
// Package for the H-bridge motor drive sequencer.
// Holds the state, operation and command codes, register defaults and the stream field layout.
// No dependencies.
package hbms_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_POS,
    ST_SDELTA,
    ST_ITV,
    ST_EMIT,
    ST_VISIT
  } state_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  localparam logic [1:0] CMD_HOST = 2'd0;
  localparam logic [1:0] CMD_ENC  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] REG_MAX_DRIVE = 2'd0;
  localparam logic [1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_STALE     = 2'd2;
  localparam logic [1:0] REG_POS_MASK  = 2'd3;

  localparam logic [14:0] MAX_DRIVE_RST = 15'd2400;
  localparam logic [3:0]  TIMEOUT_RST   = 4'd4;
  localparam logic [7:0]  STALE_RST     = 8'd25;
  localparam logic [3:0]  POS_MASK_RST  = 4'd3;

  // Truncation toward zero of a division by 0x8000 adds this before the shift.
  localparam logic [31:0] SCALE_ROUND = 32'h0000_7FFF;
  localparam logic [7:0]  FRAMES_SAT  = 8'd255;
  localparam int          VISIT_LIMIT = 4;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 136;

endpackage

// ===== rtl/hbms_alu.sv =====
// Shared arithmetic unit of the H-bridge motor drive sequencer: 32-bit add and
// subtract, and a 16 x 16 signed multiply. Depends on hbms_pkg.
module hbms_alu (
  input  hbms_pkg::alu_req_t req,
  output logic [31:0]        y
);

  logic signed [31:0] prod;

  assign prod = $signed(req.a[15:0]) * $signed(req.b[15:0]);

  always_comb begin
    unique case (req.op)
      hbms_pkg::ALU_ADD: y = req.a + req.b;
      hbms_pkg::ALU_SUB: y = req.a - req.b;
      hbms_pkg::ALU_MUL: y = prod;
      default:           y = req.a;
    endcase
  end

endmodule

// ===== rtl/hbridge_motor_drive_sequencer_top.sv =====
// Top level of the H-bridge motor drive sequencer: stream ports, register port,
// sequencer and per-motor state. Depends on hbms_pkg and hbms_alu.
//
// One input request is taken at a time; a host power request is taken in idle.
// An encoder sample steps through multiply, scale, position, signed delta and
// interval (the last two skipped when its delta is zero), then emit. The
// sequencer runs every multiply, add and subtract through one shared unit, in
// order: scale the request, then accumulate the position, sign the delta and
// form the edge interval. A drive tick gives one report per visited motor. Each
// emit and visit step waits for a free output register, so a stall stretches it.
module hbridge_motor_drive_sequencer_top #(
  parameter int MOTORS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // power_0, power_1, power_2, power_3, motor_index, frame_start,
  // encoder_delta, encoder_time, zero fill
  input  logic [hbms_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // command
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // report_motor, position, signed_delta, interval, delta_fresh, delta_stale,
  // high_side_on, pins_reconfigured, compare_a, compare_b, zero fill
  output logic [hbms_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // report_kind
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [14:0]                         cfg_data
);

  localparam int IDX_W  = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int VISITS = (MOTORS < hbms_pkg::VISIT_LIMIT) ? MOTORS : hbms_pkg::VISIT_LIMIT;

  // Configuration registers.
  logic [14:0] max_drive;
  logic [3:0]  timeout_frames;
  logic [7:0]  stale_limit;
  logic [3:0]  pos_mask;

  // Per-motor state.
  logic signed [15:0] host_request [MOTORS];
  logic signed [15:0] drive_level  [MOTORS];
  logic [31:0]        motor_pos    [MOTORS];
  logic [31:0]        prev_edge    [MOTORS];
  logic               dir          [MOTORS];
  logic               pins_ready   [MOTORS];
  logic [7:0]         frames       [MOTORS];
  logic [14:0]        fwd_cmp      [MOTORS];
  logic [14:0]        rev_cmp      [MOTORS];
  logic [3:0]         silence;

  hbms_pkg::state_t state, state_next;

  // Request being worked on.
  logic [1:0]  enc_motor;
  logic [31:0] enc_delta;
  logic [31:0] enc_time;
  logic [31:0] acc;
  logic [31:0] sdelta;
  logic [31:0] itv;
  logic        fresh;
  logic        stale;
  logic [1:0]  visit;

  // Output register.
  logic                               out_valid;
  logic [hbms_pkg::OUT_DATA_W-1:0]    out_data;
  logic                               out_kind;
  logic                               out_last;

  logic                 accept;
  logic                 out_free;
  logic                 out_load;
  logic [IDX_W-1:0]     midx;
  logic [IDX_W-1:0]     vidx;
  logic                 motor_ok;
  logic [1:0]           in_motor;
  logic                 in_frame;
  logic [7:0]           frames_inc;
  logic signed [15:0]   lvl;
  logic                 lvl_dir;
  logic                 lvl_trans;
  logic                 last_visit;
  hbms_pkg::alu_req_t   alu_req;
  logic [31:0]          alu_y;

  assign s_axis_tready = (state == hbms_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign out_load      = out_free && ((state == hbms_pkg::ST_EMIT) ||
                                      (state == hbms_pkg::ST_VISIT));
  assign in_motor      = s_axis_tdata[65:64];
  assign in_frame      = s_axis_tdata[66];
  assign motor_ok      = (int'(in_motor) < MOTORS);
  assign midx          = IDX_W'(enc_motor);
  assign vidx          = IDX_W'(visit);
  assign frames_inc    = (frames[midx] == hbms_pkg::FRAMES_SAT) ? frames[midx]
                                                                 : frames[midx] + 8'd1;
  assign lvl           = drive_level[vidx];
  assign lvl_dir       = !lvl[15];
  assign lvl_trans     = (lvl == 16'sd0) || (dir[vidx] != lvl_dir);
  assign last_visit    = (int'(visit) == VISITS - 1);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  hbms_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      hbms_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == hbms_pkg::CMD_ENC && motor_ok) begin
            state_next = hbms_pkg::ST_MUL;
          end else if (s_axis_tuser == hbms_pkg::CMD_TICK) begin
            state_next = hbms_pkg::ST_VISIT;
          end
        end
      end
      hbms_pkg::ST_MUL:   state_next = hbms_pkg::ST_SCALE;
      hbms_pkg::ST_SCALE: state_next = hbms_pkg::ST_POS;
      hbms_pkg::ST_POS: begin
        state_next = (enc_delta == 32'd0) ? hbms_pkg::ST_EMIT : hbms_pkg::ST_SDELTA;
      end
      hbms_pkg::ST_SDELTA: state_next = hbms_pkg::ST_ITV;
      hbms_pkg::ST_ITV:    state_next = hbms_pkg::ST_EMIT;
      hbms_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = hbms_pkg::ST_IDLE;
        end
      end
      hbms_pkg::ST_VISIT: begin
        if (out_free && (!pins_ready[vidx] || last_visit)) begin
          state_next = hbms_pkg::ST_IDLE;
        end
      end
      default: state_next = hbms_pkg::ST_IDLE;
    endcase
  end

  // Shared unit control.
  always_comb begin
    alu_req.op = hbms_pkg::ALU_ADD;
    alu_req.a  = 32'd0;
    alu_req.b  = 32'd0;
    unique case (state)
      hbms_pkg::ST_MUL: begin
        alu_req.op = hbms_pkg::ALU_MUL;
        alu_req.a  = {17'd0, max_drive};
        alu_req.b  = {{16{host_request[midx][15]}}, host_request[midx]};
      end
      hbms_pkg::ST_SCALE: begin
        alu_req.a = acc;
        alu_req.b = acc[31] ? hbms_pkg::SCALE_ROUND : 32'd0;
      end
      hbms_pkg::ST_POS: begin
        // A masked motor in reverse moves its position down.
        alu_req.op = (pos_mask[enc_motor] && !dir[midx]) ? hbms_pkg::ALU_SUB
                                                         : hbms_pkg::ALU_ADD;
        alu_req.a  = motor_pos[midx];
        alu_req.b  = enc_delta;
      end
      hbms_pkg::ST_SDELTA: begin
        alu_req.op = dir[midx] ? hbms_pkg::ALU_ADD : hbms_pkg::ALU_SUB;
        alu_req.a  = 32'd0;
        alu_req.b  = enc_delta;
      end
      hbms_pkg::ST_ITV: begin
        alu_req.op = hbms_pkg::ALU_SUB;
        alu_req.a  = prev_edge[midx];
        alu_req.b  = enc_time;
      end
      hbms_pkg::ST_VISIT: begin
        alu_req.op = hbms_pkg::ALU_SUB;
        alu_req.a  = 32'd0;
        alu_req.b  = {{16{lvl[15]}}, lvl};
      end
      default: begin
        alu_req.op = hbms_pkg::ALU_ADD;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_drive      <= hbms_pkg::MAX_DRIVE_RST;
      timeout_frames <= hbms_pkg::TIMEOUT_RST;
      stale_limit    <= hbms_pkg::STALE_RST;
      pos_mask       <= hbms_pkg::POS_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbms_pkg::REG_MAX_DRIVE: max_drive      <= cfg_data;
        hbms_pkg::REG_TIMEOUT:   timeout_frames <= cfg_data[3:0];
        hbms_pkg::REG_STALE:     stale_limit    <= cfg_data[7:0];
        hbms_pkg::REG_POS_MASK:  pos_mask       <= cfg_data[3:0];
        default:                 max_drive      <= cfg_data;
      endcase
    end
  end

  // Sequencer, motor state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hbms_pkg::ST_IDLE;
      silence   <= 4'd0;
      out_valid <= 1'b0;
      visit     <= 2'd0;
      for (int i = 0; i < MOTORS; i++) begin
        host_request[i] <= 16'sd0;
        drive_level[i]  <= 16'sd0;
        motor_pos[i]    <= 32'd0;
        prev_edge[i]    <= 32'd0;
        dir[i]          <= 1'b0;
        pins_ready[i]   <= 1'b0;
        frames[i]       <= 8'd0;
        fwd_cmp[i]      <= 15'd0;
        rev_cmp[i]      <= 15'd0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        hbms_pkg::ST_IDLE: begin
          if (accept) begin
            enc_motor <= in_motor;
            enc_delta <= s_axis_tdata[98:67];
            enc_time  <= s_axis_tdata[130:99];
            sdelta    <= 32'd0;
            itv       <= 32'd0;
            fresh     <= 1'b0;
            visit     <= 2'd0;
            if (s_axis_tuser == hbms_pkg::CMD_HOST) begin
              for (int i = 0; i < MOTORS; i++) begin
                if (i < hbms_pkg::VISIT_LIMIT) begin
                  host_request[i] <= s_axis_tdata[16*i +: 16];
                end
              end
              silence <= timeout_frames;
            end else if (s_axis_tuser == hbms_pkg::CMD_ENC && in_frame) begin
              // Silence watchdog: once the countdown is spent, drop all requests.
              if (silence == 4'd0) begin
                for (int i = 0; i < MOTORS; i++) begin
                  host_request[i] <= 16'sd0;
                end
              end else begin
                silence <= silence - 4'd1;
              end
            end
          end
        end
        hbms_pkg::ST_MUL: begin
          acc <= alu_y;
        end
        hbms_pkg::ST_SCALE: begin
          drive_level[midx] <= alu_y[30:15];
          frames[midx]      <= frames_inc;
          stale             <= (frames_inc > stale_limit);
        end
        hbms_pkg::ST_POS: begin
          if (enc_delta != 32'd0) begin
            motor_pos[midx] <= alu_y;
          end
        end
        hbms_pkg::ST_SDELTA: begin
          sdelta <= alu_y;
        end
        hbms_pkg::ST_ITV: begin
          itv             <= alu_y;
          prev_edge[midx] <= enc_time;
          frames[midx]    <= 8'd0;
          fresh           <= 1'b1;
          stale           <= 1'b0;
        end
        hbms_pkg::ST_EMIT: begin
          if (out_free) begin
            out_kind  <= 1'b0;
            out_last  <= 1'b1;
            out_data  <= {4'd0, rev_cmp[midx], fwd_cmp[midx], 1'b0, dir[midx],
                          stale, fresh, itv, sdelta, motor_pos[midx], enc_motor};
          end
        end
        hbms_pkg::ST_VISIT: begin
          if (out_free) begin
            out_kind  <= 1'b1;
            visit     <= visit + 2'd1;
            if (!pins_ready[vidx]) begin
              // Unconfigured motor: latch direction and end the tick here.
              dir[vidx]        <= lvl_dir;
              pins_ready[vidx] <= 1'b1;
              out_last         <= 1'b1;
              out_data <= {4'd0, rev_cmp[vidx], fwd_cmp[vidx], 1'b1, lvl_dir,
                           2'b00, 64'd0, motor_pos[vidx], visit};
            end else if (lvl_trans) begin
              fwd_cmp[vidx]    <= 15'd0;
              rev_cmp[vidx]    <= 15'd0;
              pins_ready[vidx] <= 1'b0;
              out_last         <= last_visit;
              out_data <= {4'd0, 15'd0, 15'd0, 1'b0, dir[vidx],
                           2'b00, 64'd0, motor_pos[vidx], visit};
            end else if (lvl_dir) begin
              fwd_cmp[vidx] <= lvl[14:0];
              out_last      <= last_visit;
              out_data <= {4'd0, rev_cmp[vidx], lvl[14:0], 1'b0, dir[vidx],
                           2'b00, 64'd0, motor_pos[vidx], visit};
            end else begin
              rev_cmp[vidx] <= alu_y[14:0];
              out_last      <= last_visit;
              out_data <= {4'd0, alu_y[14:0], fwd_cmp[vidx], 1'b0, dir[vidx],
                           2'b00, 64'd0, motor_pos[vidx], visit};
            end
          end
        end
        default: begin
          visit <= 2'd0;
        end
      endcase
    end
  end

endmodule

// ===== bench/hbms_report_checker.sv =====
// Report checker for the H-bridge motor drive sequencer bench.
// Watches the request, report and register ports, predicts every report and compares.
// Depends on hbms_pkg.
`timescale 1ns / 100ps

module hbms_report_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [hbms_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]                      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [hbms_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser,
  input  logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [14:0]                     cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              reports_checked,
  output int                              requests_seen
);
  import hbms_pkg::*;

  localparam logic KIND_ENC   = 1'b0;
  localparam logic KIND_DRIVE = 1'b1;
  localparam int   FULL_SCALE = 32768;

  typedef struct {
    logic        kind;
    logic [1:0]  motor;
    logic [31:0] position;
    logic [31:0] sdelta;
    logic [31:0] interval;
    logic        fresh;
    logic        stale;
    logic        high_side;
    logic        reconf;
    logic [14:0] cmp_a;
    logic [14:0] cmp_b;
    logic        last;
  } report_t;

  report_t expected_reports[$];
  report_t want;
  report_t got;
  int      mismatches;
  int      checked;
  int      seen;

  // Register copies.
  logic [14:0] max_counts;
  logic [3:0]  timeout_frames;
  logic [7:0]  stale_limit;
  logic [3:0]  pos_mask;

  // Per-motor state of the drive.
  logic signed [15:0] power_req [4];
  logic [3:0]         silence;
  int                 drive_lvl [4];
  logic [31:0]        pos [4];
  logic [31:0]        edge_stamp [4];
  bit                 dir_latched [4];
  bit                 pins_set [4];
  logic [7:0]         still_frames [4];
  logic [14:0]        fwd_cmp [4];
  logic [14:0]        rev_cmp [4];

  function automatic report_t make_report(input logic kind, input int m,
                                          input logic [31:0] sd, input logic [31:0] itv,
                                          input bit fresh, input bit stale, input bit reconf);
    report_t r;
    r.kind      = kind;
    r.motor     = m[1:0];
    r.position  = pos[m];
    r.sdelta    = sd;
    r.interval  = itv;
    r.fresh     = fresh;
    r.stale     = stale;
    r.high_side = dir_latched[m];
    r.reconf    = reconf;
    r.cmp_a     = fwd_cmp[m];
    r.cmp_b     = rev_cmp[m];
    r.last      = 1'b0;
    return r;
  endfunction

  task automatic predict_request(input logic [1:0] cmd, input logic [IN_DATA_W-1:0] data);
    int          m;
    int          i;
    int          lvl;
    int          neg;
    int          first_new;
    bit          fwd;
    bit          swap;
    bit          fresh;
    bit          stale;
    bit          done;
    logic [31:0] d;
    logic [31:0] t;
    logic [31:0] sd;
    logic [31:0] itv;
    report_t     r;
    if (cmd == CMD_HOST) begin
      for (i = 0; i < 4; i++) power_req[i] = data[16*i +: 16];
      silence = timeout_frames;
    end else if (cmd == CMD_ENC) begin
      m   = data[65:64];
      d   = data[98:67];
      t   = data[130:99];
      sd  = '0;
      itv = '0;
      fresh = 1'b0;
      // The watchdog runs before the sample is used.
      if (data[66]) begin
        if (silence == 0) begin
          for (i = 0; i < 4; i++) power_req[i] = '0;
        end else begin
          silence = silence - 1'b1;
        end
      end
      drive_lvl[m] = (int'(max_counts) * int'(power_req[m])) / FULL_SCALE;
      if (still_frames[m] != FRAMES_SAT) still_frames[m] = still_frames[m] + 1'b1;
      stale = still_frames[m] > stale_limit;
      if (d != 0) begin
        sd = dir_latched[m] ? d : -d;
        pos[m] = pos[m] + (pos_mask[m] ? sd : d);
        itv = edge_stamp[m] - t;
        edge_stamp[m] = t;
        still_frames[m] = '0;
        fresh = 1'b1;
        stale = 1'b0;
      end
      r = make_report(KIND_ENC, m, sd, itv, fresh, stale, 1'b0);
      r.last = 1'b1;
      expected_reports.push_back(r);
    end else if (cmd == CMD_TICK) begin
      done = 1'b0;
      first_new = expected_reports.size();
      for (i = 0; i < VISIT_LIMIT && !done; i++) begin
        lvl  = drive_lvl[i];
        fwd  = lvl >= 0;
        swap = (lvl == 0) || (dir_latched[i] != fwd);
        if (!pins_set[i]) begin
          // An unconfigured motor takes its direction and ends the tick.
          dir_latched[i] = fwd;
          pins_set[i] = 1'b1;
          expected_reports.push_back(make_report(KIND_DRIVE, i, '0, '0, 1'b0, 1'b0, 1'b1));
          done = 1'b1;
        end else begin
          if (swap) begin
            fwd_cmp[i] = '0;
            rev_cmp[i] = '0;
            pins_set[i] = 1'b0;
          end else if (fwd) begin
            fwd_cmp[i] = lvl[14:0];
          end else begin
            neg = -lvl;
            rev_cmp[i] = neg[14:0];
          end
          expected_reports.push_back(make_report(KIND_DRIVE, i, '0, '0, 1'b0, 1'b0, 1'b0));
        end
      end
      if (expected_reports.size() > first_new)
        expected_reports[expected_reports.size()-1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      max_counts     = MAX_DRIVE_RST;
      timeout_frames = TIMEOUT_RST;
      stale_limit    = STALE_RST;
      pos_mask       = POS_MASK_RST;
      silence        = '0;
      for (int i = 0; i < 4; i++) begin
        power_req[i]    = '0;
        drive_lvl[i]    = 0;
        pos[i]          = '0;
        edge_stamp[i]   = '0;
        dir_latched[i]  = 1'b0;
        pins_set[i]     = 1'b0;
        still_frames[i] = '0;
        fwd_cmp[i]      = '0;
        rev_cmp[i]      = '0;
      end
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_DRIVE: max_counts     = cfg_data;
          REG_TIMEOUT:   timeout_frames = cfg_data[3:0];
          REG_STALE:     stale_limit    = cfg_data[7:0];
          REG_POS_MASK:  pos_mask       = cfg_data[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(s_axis_tuser, s_axis_tdata);
        seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = m_axis_tuser;
        got.motor     = m_axis_tdata[1:0];
        got.position  = m_axis_tdata[33:2];
        got.sdelta    = m_axis_tdata[65:34];
        got.interval  = m_axis_tdata[97:66];
        got.fresh     = m_axis_tdata[98];
        got.stale     = m_axis_tdata[99];
        got.high_side = m_axis_tdata[100];
        got.reconf    = m_axis_tdata[101];
        got.cmp_a     = m_axis_tdata[116:102];
        got.cmp_b     = m_axis_tdata[131:117];
        got.last      = m_axis_tlast;
        if (expected_reports.size() == 0) begin
          mismatches++;
          $error("report for motor %0d arrived with none expected", got.motor);
        end else begin
          want = expected_reports.pop_front();
          checked++;
          check_field("report_kind", 32'(want.kind), 32'(got.kind));
          check_field("report_motor", 32'(want.motor), 32'(got.motor));
          check_field("position", want.position, got.position);
          check_field("signed_delta", want.sdelta, got.sdelta);
          check_field("interval", want.interval, got.interval);
          check_field("delta_fresh", 32'(want.fresh), 32'(got.fresh));
          check_field("delta_stale", 32'(want.stale), 32'(got.stale));
          check_field("high_side_on", 32'(want.high_side), 32'(got.high_side));
          check_field("pins_reconfigured", 32'(want.reconf), 32'(got.reconf));
          check_field("compare_a", 32'(want.cmp_a), 32'(got.cmp_a));
          check_field("compare_b", 32'(want.cmp_b), 32'(got.cmp_b));
          check_field("last", 32'(want.last), 32'(got.last));
        end
      end
    end
    errors          <= mismatches;
    pending         <= expected_reports.size();
    reports_checked <= checked;
    requests_seen   <= seen;
  end

endmodule

// ===== bench/hbridge_motor_drive_sequencer_top_tb.sv =====
// Testbench top for the H-bridge motor drive sequencer: clock, reset, request and
// register stimulus, report-side back-pressure and the verdict.
// Depends on hbms_pkg, the block and hbms_report_checker.
`timescale 1ns / 100ps

module hbridge_motor_drive_sequencer_top_tb;
  import hbms_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         SETTLE     = 12;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [14:0]           cfg_data;

  int chk_errors;
  int chk_pending;
  int chk_reports;
  int chk_requests;

  bit steady;
  int hold_count;
  int holds_done;
  int requests_sent;
  int settings_used;

  hbridge_motor_drive_sequencer_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  hbms_report_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .errors          (chk_errors),
    .pending         (chk_pending),
    .reports_checked (chk_reports),
    .requests_seen   (chk_requests)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Report side: random stalls, none while steady, and a long hold-off on demand.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (holds_done != hold_count) begin
        holds_done++;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 7);
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_request(
      input logic [15:0] p0, input logic [15:0] p1, input logic [15:0] p2,
      input logic [15:0] p3, input logic [1:0] m, input logic fs,
      input logic [31:0] d, input logic [31:0] t);
    return {5'b0, t, d, fs, m, p3, p2, p1, p0};
  endfunction

  function automatic logic [15:0] rand_power();
    int v;
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: begin
        v = int'($urandom_range(0, 200)) - 100;
        return v[15:0];
      end
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_delta();
    int v;
    case ($urandom_range(0, 6))
      0, 1: return 32'd0;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: begin
        v = int'($urandom_range(0, 40)) - 20;
        return v;
      end
      default: return $urandom();
    endcase
  endfunction

  // Offers one request; valid stays up after acceptance until the next decision.
  task automatic send(input logic [1:0] cmd, input logic [IN_DATA_W-1:0] data);
    while (!steady && $urandom_range(0, 99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  task automatic send_host(input logic [15:0] p0, input logic [15:0] p1,
                           input logic [15:0] p2, input logic [15:0] p3);
    send(CMD_HOST, pack_request(p0, p1, p2, p3, 2'($urandom()), 1'($urandom()),
                                $urandom(), $urandom()));
  endtask

  task automatic send_enc(input logic [1:0] m, input logic fs, input logic [31:0] d,
                          input logic [31:0] t);
    send(CMD_ENC, pack_request(16'($urandom()), 16'($urandom()), 16'($urandom()),
                               16'($urandom()), m, fs, d, t));
  endtask

  task automatic send_tick();
    send(CMD_TICK, IN_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()}));
  endtask

  // Lets the block go idle; host requests give no report, so it also waits the settle time.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(input logic [14:0] max_counts, input logic [3:0] timeout_frames,
                          input logic [7:0] stale_limit, input logic [3:0] pos_mask);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_DRIVE;
    cfg_data  <= max_counts;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= {11'b0, timeout_frames};
    @(posedge clk);
    cfg_index <= REG_STALE;
    cfg_data  <= {7'b0, stale_limit};
    @(posedge clk);
    cfg_index <= REG_POS_MASK;
    cfg_data  <= {11'b0, pos_mask};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly whole frames: an optional power update, samples in motor order, then a tick.
  task automatic random_traffic(input int n_req);
    int start;
    int pick;
    int k;
    bit first;
    start = requests_sent;
    while (requests_sent - start < n_req) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 2) == 0)
          send_host(rand_power(), rand_power(), rand_power(), rand_power());
        first = 1'b1;
        for (k = 0; k < 4; k++) begin
          if ($urandom_range(0, 4) != 0) begin
            send_enc(k[1:0], first, rand_delta(), $urandom());
            first = 1'b0;
          end
        end
        send_tick();
      end else if (pick < 70) begin
        send_host(rand_power(), rand_power(), rand_power(), rand_power());
      end else if (pick < 85) begin
        send_enc(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_delta(),
                 $urandom());
      end else if (pick < 95) begin
        send_tick();
      end else begin
        send(CMD_UNUSED,
             IN_DATA_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()}));
      end
    end
  endtask

  initial begin
    int k;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_HOST;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_MAX_DRIVE;
    cfg_data      <= '0;
    steady        <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on reset register values.
    send_tick();
    send_host(16'h7FFF, 16'h8000, 16'h0000, 16'h0001);
    send_enc(2'd0, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_enc(2'd1, 1'b0, 32'h8000_0000, 32'h0000_0000);
    send_enc(2'd2, 1'b0, 32'd0, 32'd5);
    send_enc(2'd3, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
    repeat (4) send_tick();
    send(CMD_UNUSED, '1);
    send_host(16'hFFFF, 16'h4000, 16'hC000, 16'h8000);
    send_enc(2'd0, 1'b1, 32'd3, 32'd100);
    send_enc(2'd1, 1'b0, 32'hFFFF_FFFD, 32'd90);
    send_enc(2'd2, 1'b0, 32'd7, 32'd80);
    send_enc(2'd3, 1'b0, 32'd1, 32'd70);
    repeat (2) send_tick();
    // Frame starts past the countdown so the watchdog clears the requests.
    for (k = 0; k < 5; k++) send_enc(2'd0, 1'b1, 32'd0, 32'd0);
    send_tick();
    drain();

    // Top extremes with no idling on either side.
    steady <= 1'b1;
    set_regs(15'd32767, 4'd15, 8'd255, 4'hF);
    random_traffic(40);
    drain();
    steady <= 1'b0;

    set_regs(15'd1, 4'd0, 8'd0, 4'h0);
    random_traffic(30);
    drain();

    set_regs(15'($urandom_range(1, 32767)), 4'($urandom_range(0, 15)),
             8'($urandom_range(0, 8)), 4'($urandom_range(0, 15)));
    hold_count <= hold_count + 1;
    random_traffic(50);
    drain();

    set_regs(15'($urandom_range(1, 32767)), 4'($urandom_range(0, 15)),
             8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
    random_traffic(50);
    drain();

    // A motor that never moves reads stale once its frame count passes the limit.
    set_regs(15'($urandom_range(1, 32767)), 4'($urandom_range(0, 15)), 8'd2,
             4'($urandom_range(0, 15)));
    for (k = 0; k < 12; k++) send_enc(2'd3, 1'($urandom_range(0, 1)), 32'd0, $urandom());
    random_traffic(4);
    drain();

    $display("Run covered %0d requests, %0d reports checked, across %0d register settings.",
             chk_requests, chk_reports, settings_used);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
